// ----- src/erst_pkg.sv -----
`default_nettype none
package erst_pkg;
    localparam int SLOT_COUNT = 8;
    localparam int QUEUE_DEPTH = 8;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_W = SLOT_W + QPTR_W;
    localparam int MEM_DEPTH = SLOT_COUNT * QUEUE_DEPTH;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_REGISTER = 2'd0,
        CMD_DELIVER  = 2'd1,
        CMD_RECEIVE  = 2'd2,
        CMD_RELEASE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_REGISTERED = 3'd1,
        ST_FULL_TABLE = 3'd2,
        ST_BAD_SLOT   = 3'd3,
        ST_EMPTY      = 3'd4,
        ST_DISCARDED  = 3'd5,
        ST_REPLY      = 3'd6,
        ST_QUEUE_FULL = 3'd7
    } status_t;

    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;

    // Classified work handed from the front part to the back part.
    typedef enum logic [1:0] {
        OP_DIRECT  = 2'd0,
        OP_REGISTER = 2'd1,
        OP_CHECKED = 2'd2
    } op_t;

    typedef struct packed {
        op_t          op;
        cmd_t         cmd;
        logic [2:0]   status;
        logic [2:0]   slot_out;
        logic [15:0]  handle;
        logic         free_handle;
        logic [31:0]  remote_ip;
        logic [SLOT_W-1:0] slot;
    } job_t;

    typedef enum logic [1:0] {
        BS_IDLE  = 2'd0,
        BS_READ  = 2'd1,
        BS_DRAIN = 2'd2,
        BS_SEND  = 2'd3
    } back_state_t;
endpackage
`default_nettype wire

// ----- src/erst_in_if.sv -----
`default_nettype none
interface erst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] remote_ip;
    logic [7:0]  icmp_type;
    logic [15:0] slot_id;
    logic [15:0] packet_handle;
    modport source (output valid, cmd, remote_ip, icmp_type, slot_id, packet_handle,
                    input ready);
    modport sink (input valid, cmd, remote_ip, icmp_type, slot_id, packet_handle,
                  output ready);
endinterface
`default_nettype wire

// ----- src/erst_out_if.sv -----
`default_nettype none
interface erst_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  slot_out;
    logic [15:0] handle_out;
    logic        free_handle;
    logic        last;
    modport source (output valid, status, slot_out, handle_out, free_handle, last,
                    input ready);
    modport sink (input valid, status, slot_out, handle_out, free_handle, last,
                  output ready);
endinterface
`default_nettype wire

// ----- src/erst_front.sv -----
`default_nettype none
// Classifies each beat and settles those that need no slot state.
module erst_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    erst_in_if.sink       in_ch,
    output erst_pkg::job_t job,
    output logic          job_valid,
    input  wire logic     job_ready
);
    erst_pkg::job_t j;
    logic in_range;

    assign in_range = in_ch.slot_id < 16'(erst_pkg::SLOT_COUNT);

    always_comb
    begin
        j = '0;
        j.cmd = erst_pkg::cmd_t'(in_ch.cmd);
        j.remote_ip = in_ch.remote_ip;
        j.slot = in_ch.slot_id[erst_pkg::SLOT_W-1:0];
        j.slot_out = in_ch.slot_id[2:0];
        case (erst_pkg::cmd_t'(in_ch.cmd))
            erst_pkg::CMD_REGISTER:
            begin
                j.op = erst_pkg::OP_REGISTER;
            end
            erst_pkg::CMD_DELIVER:
            begin
                j.handle = in_ch.packet_handle;
                j.free_handle = 1'b1;
                if (in_ch.icmp_type != erst_pkg::TYPE_ECHO_REPLY &&
                    in_ch.icmp_type != erst_pkg::TYPE_ECHO_REQUEST)
                begin
                    j.op = erst_pkg::OP_DIRECT;
                    j.status = erst_pkg::ST_DISCARDED;
                    j.slot_out = 3'd0;
                end
                else if (in_ch.icmp_type == erst_pkg::TYPE_ECHO_REQUEST)
                begin
                    j.op = erst_pkg::OP_DIRECT;
                    j.status = erst_pkg::ST_REPLY;
                    j.slot_out = 3'd0;
                end
                else if (!in_range)
                begin
                    j.op = erst_pkg::OP_DIRECT;
                    j.status = erst_pkg::ST_BAD_SLOT;
                end
                else
                begin
                    j.op = erst_pkg::OP_CHECKED;
                end
            end
            default:
            begin
                if (!in_range)
                begin
                    j.op = erst_pkg::OP_DIRECT;
                    j.status = erst_pkg::ST_BAD_SLOT;
                end
                else
                begin
                    j.op = erst_pkg::OP_CHECKED;
                end
            end
        endcase
    end

    erst_pkg::job_t fifo_reg [erst_pkg::FIFO_DEPTH];
    logic wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic push, pop;

    assign in_ch.ready = count_reg != 2'(erst_pkg::FIFO_DEPTH);
    assign push = in_ch.valid && in_ch.ready;
    assign job_valid = count_reg != 2'd0;
    assign pop = job_valid && job_ready;
    assign job = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= j;
        end
    end
endmodule
`default_nettype wire

// ----- src/erst_back.sv -----
`default_nettype none
// Carries out classified jobs against the slot table and the handle memory.
module erst_back (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire erst_pkg::job_t job,
    input  wire logic      job_valid,
    output logic           job_ready,
    erst_out_if.source     out_ch
);
    localparam int SW = erst_pkg::SLOT_W;
    localparam int PW = erst_pkg::QPTR_W;
    localparam int CW = erst_pkg::QCNT_W;
    localparam int N = erst_pkg::SLOT_COUNT;

    logic [N-1:0]  busy_reg, busy_next;
    logic [31:0]   addr_reg [N];
    logic [PW-1:0] head_reg [N];
    logic [PW-1:0] tail_reg [N];
    logic [CW-1:0] cnt_reg [N];
    logic [15:0]   mem [erst_pkg::MEM_DEPTH];
    logic [15:0]   mem_q_reg;

    erst_pkg::back_state_t state_reg, state_next;
    erst_pkg::job_t job_reg;

    logic          ov_reg, ov_next;
    logic [2:0]    o_status_reg, o_status_next, o_slot_reg, o_slot_next;
    logic [15:0]   o_handle_reg, o_handle_next;
    logic          o_free_reg, o_free_next, o_last_reg, o_last_next;
    logic          out_free;

    assign out_ch.valid = ov_reg;
    assign out_ch.status = o_status_reg;
    assign out_ch.slot_out = o_slot_reg;
    assign out_ch.handle_out = o_handle_reg;
    assign out_ch.free_handle = o_free_reg;
    assign out_ch.last = o_last_reg;
    assign out_free = !ov_reg || out_ch.ready;

    // Register search: lowest free slot and first busy slot holding the address.
    logic          hit, has_free;
    logic [SW-1:0] hit_slot, free_slot;
    always_comb
    begin
        hit = 1'b0;
        has_free = 1'b0;
        hit_slot = '0;
        free_slot = '0;
        for (int s = N - 1; s >= 0; s--)
        begin
            if (!busy_reg[s])
            begin
                has_free = 1'b1;
                free_slot = SW'(s);
            end
            else if (addr_reg[s] == job_reg.remote_ip)
            begin
                hit = 1'b1;
                hit_slot = SW'(s);
            end
        end
    end

    logic [SW-1:0] s_cur;
    logic          mem_rd, mem_wr, do_reg, do_pop, do_push, do_free;
    assign s_cur = job_reg.slot;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            erst_pkg::BS_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = erst_pkg::BS_SEND;
                end
            end
            erst_pkg::BS_SEND:
            begin
                if (out_free)
                begin
                    if (job_reg.op == erst_pkg::OP_CHECKED && busy_reg[s_cur] &&
                        ((job_reg.cmd == erst_pkg::CMD_RECEIVE && cnt_reg[s_cur] != '0) ||
                         (job_reg.cmd == erst_pkg::CMD_RELEASE && cnt_reg[s_cur] != '0)))
                    begin
                        state_next = erst_pkg::BS_READ;
                    end
                    else
                    begin
                        state_next = erst_pkg::BS_IDLE;
                    end
                end
            end
            erst_pkg::BS_READ:
            begin
                state_next = erst_pkg::BS_DRAIN;
            end
            erst_pkg::BS_DRAIN:
            begin
                if (out_free)
                begin
                    if (job_reg.cmd == erst_pkg::CMD_RELEASE)
                    begin
                        state_next = (cnt_reg[s_cur] == CW'(1)) ? erst_pkg::BS_SEND
                                                                : erst_pkg::BS_READ;
                    end
                    else
                    begin
                        state_next = erst_pkg::BS_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = erst_pkg::BS_IDLE;
            end
        endcase
    end

    // Outputs and table updates.
    always_comb
    begin
        job_ready = 1'b0;
        ov_next = ov_reg && !out_ch.ready;
        o_status_next = o_status_reg;
        o_slot_next = o_slot_reg;
        o_handle_next = o_handle_reg;
        o_free_next = o_free_reg;
        o_last_next = o_last_reg;
        busy_next = busy_reg;
        mem_rd = 1'b0;
        mem_wr = 1'b0;
        do_reg = 1'b0;
        do_pop = 1'b0;
        do_push = 1'b0;
        do_free = 1'b0;
        case (state_reg)
            erst_pkg::BS_IDLE:
            begin
                job_ready = 1'b1;
            end
            erst_pkg::BS_SEND:
            begin
                if (out_free)
                begin
                    o_slot_next = job_reg.slot_out;
                    o_handle_next = job_reg.handle;
                    o_free_next = job_reg.free_handle;
                    o_status_next = job_reg.status;
                    o_last_next = 1'b1;
                    ov_next = 1'b1;
                    case (job_reg.op)
                        erst_pkg::OP_REGISTER:
                        begin
                            o_handle_next = '0;
                            o_free_next = 1'b0;
                            if (hit)
                            begin
                                o_status_next = erst_pkg::ST_REGISTERED;
                                o_slot_next = 3'(hit_slot);
                            end
                            else if (!has_free)
                            begin
                                o_status_next = erst_pkg::ST_FULL_TABLE;
                                o_slot_next = 3'd0;
                            end
                            else
                            begin
                                o_status_next = erst_pkg::ST_OK;
                                o_slot_next = 3'(free_slot);
                                busy_next[free_slot] = 1'b1;
                                do_reg = 1'b1;
                            end
                        end
                        erst_pkg::OP_CHECKED:
                        begin
                            if (job_reg.cmd == erst_pkg::CMD_DELIVER)
                            begin
                                if (!busy_reg[s_cur] ||
                                    addr_reg[s_cur] != job_reg.remote_ip)
                                begin
                                    o_status_next = erst_pkg::ST_DISCARDED;
                                end
                                else if (cnt_reg[s_cur] >= CW'(erst_pkg::QUEUE_DEPTH))
                                begin
                                    o_status_next = erst_pkg::ST_QUEUE_FULL;
                                end
                                else
                                begin
                                    o_status_next = erst_pkg::ST_OK;
                                    o_free_next = 1'b0;
                                    mem_wr = 1'b1;
                                    do_push = 1'b1;
                                end
                            end
                            else
                            begin
                                o_handle_next = '0;
                                o_free_next = 1'b0;
                                if (!busy_reg[s_cur])
                                begin
                                    o_status_next = erst_pkg::ST_BAD_SLOT;
                                end
                                else if (cnt_reg[s_cur] != '0)
                                begin
                                    ov_next = ov_reg && !out_ch.ready;
                                end
                                else if (job_reg.cmd == erst_pkg::CMD_RECEIVE)
                                begin
                                    o_status_next = erst_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    o_status_next = erst_pkg::ST_OK;
                                    busy_next[s_cur] = 1'b0;
                                    do_free = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            erst_pkg::BS_READ:
            begin
                mem_rd = 1'b1;
            end
            erst_pkg::BS_DRAIN:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_status_next = erst_pkg::ST_OK;
                    o_slot_next = job_reg.slot_out;
                    o_handle_next = mem_q_reg;
                    o_free_next = 1'b1;
                    o_last_next = job_reg.cmd != erst_pkg::CMD_RELEASE;
                    do_pop = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erst_pkg::BS_IDLE;
            busy_reg <= '0;
            ov_reg <= 1'b0;
            for (int s = 0; s < N; s++)
            begin
                head_reg[s] <= '0;
                tail_reg[s] <= '0;
                cnt_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= busy_next;
            ov_reg <= ov_next;
            if (do_reg)
            begin
                head_reg[free_slot] <= '0;
                tail_reg[free_slot] <= '0;
                cnt_reg[free_slot] <= '0;
            end
            if (do_push)
            begin
                tail_reg[s_cur] <= (tail_reg[s_cur] == PW'(erst_pkg::QUEUE_DEPTH - 1))
                                   ? '0 : tail_reg[s_cur] + 1'b1;
                cnt_reg[s_cur] <= cnt_reg[s_cur] + 1'b1;
            end
            if (do_pop)
            begin
                head_reg[s_cur] <= (head_reg[s_cur] == PW'(erst_pkg::QUEUE_DEPTH - 1))
                                   ? '0 : head_reg[s_cur] + 1'b1;
                cnt_reg[s_cur] <= cnt_reg[s_cur] - 1'b1;
            end
            if (do_free)
            begin
                cnt_reg[s_cur] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == erst_pkg::BS_IDLE && job_valid)
        begin
            job_reg <= job;
        end
        if (do_reg)
        begin
            addr_reg[free_slot] <= job_reg.remote_ip;
        end
        o_status_reg <= o_status_next;
        o_slot_reg <= o_slot_next;
        o_handle_reg <= o_handle_next;
        o_free_reg <= o_free_next;
        o_last_reg <= o_last_next;
        if (mem_wr)
        begin
            mem[{s_cur, tail_reg[s_cur]}] <= job_reg.handle;
        end
        if (mem_rd)
        begin
            mem_q_reg <= mem[{s_cur, head_reg[s_cur]}];
        end
    end
endmodule
`default_nettype wire

// ----- src/echo_reply_slot_queue_table_top.sv -----
`default_nettype none
// Echo reply slot table with a handle ring per slot.
// Input channel in_ch carries one command beat: register, deliver, receive
// or release. Output channel out_ch carries result beats; the final beat of
// a command has last set.
// A front stage classifies beats and buffers up to two of them, so the
// sender is released while the back part is still working.
// The back part handles one command at a time. Register, deliver and failed
// commands give a single result beat. A receive that dequeues goes through a
// read state before its beat, as the handle memory read is registered. A
// release emits one beat per queued handle, then a final beat.
// Reset clears every slot to free and every ring to empty; no clearing pass
// is needed. When the receiver stalls, the output register holds its beat
// and the back part waits; the front buffer then fills and drops ready.
module echo_reply_slot_queue_table_top (
    input wire logic clk,
    input wire logic rst_n,
    erst_in_if.sink     in_ch,
    erst_out_if.source  out_ch
);
    erst_pkg::job_t job;
    logic job_valid, job_ready;

    erst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    erst_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .out_ch    (out_ch)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.handle_out)
        && $stable(out_ch.last))
        else $error("result beat changed while stalled");

    a_queued_nofree: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status == erst_pkg::ST_QUEUE_FULL |-> out_ch.free_handle)
        else $error("dropped handle not freed");

    a_notlast: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last |-> out_ch.free_handle
        && out_ch.status == erst_pkg::ST_OK)
        else $error("drained beat malformed");
endmodule
`default_nettype wire
